@@ rtl/core/sdu_pkg.sv @@
// Shared types and operation codes for the step-division unit.
`timescale 1ns / 1ps
`default_nettype none

package sdu_pkg;

    // Operation codes carried in the kind field
    localparam logic [2:0] KIND_DIV0S = 3'd0;
    localparam logic [2:0] KIND_DIV0U = 3'd1;
    localparam logic [2:0] KIND_DIV1  = 3'd2;
    localparam logic [2:0] KIND_DIV2S = 3'd3;
    localparam logic [2:0] KIND_DIV3S = 3'd4;
    localparam logic [2:0] KIND_LOAD  = 3'd5;

    localparam int WORD_W   = 32;
    localparam int SIGN_BIT = WORD_W - 1;

    typedef logic [WORD_W-1:0] word_t;

    // Architectural divider state
    typedef struct packed {
        word_t high_word;
        word_t low_word;
        logic  dividend_sign;
        logic  divisor_sign;
    } sdu_state_t;

endpackage

`default_nettype wire

@@ rtl/core/sdu_req_if.sv @@
// Request channel: one operation with its operand.
`timescale 1ns / 1ps
`default_nettype none

interface sdu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] operand;

    modport source (output valid, output kind, output operand, input ready);
    modport sink   (input valid, input kind, input operand, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sdu_rsp_if.sv @@
// Response channel: divider state after one operation plus trap flag.
`timescale 1ns / 1ps
`default_nettype none

interface sdu_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] quotient_word;
    logic [31:0] remainder_word;
    logic        dividend_negative;
    logic        divisor_negative;
    logic        zero_divide_trap;

    modport source (output valid, output quotient_word, output remainder_word,
                    output dividend_negative, output divisor_negative,
                    output zero_divide_trap, input ready);
    modport sink   (input valid, input quotient_word, input remainder_word,
                    input dividend_negative, input divisor_negative,
                    input zero_divide_trap, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sdu_step.sv @@
// Combinational next-state logic for one divider operation.
`timescale 1ns / 1ps
`default_nettype none

module sdu_step (
    input  wire logic [2:0]         kind,
    input  wire sdu_pkg::word_t     operand,
    input  wire sdu_pkg::sdu_state_t state_cur,
    output sdu_pkg::sdu_state_t     state_nxt,
    output logic                    trap
);

    sdu_pkg::word_t shl_high;
    sdu_pkg::word_t shl_low;
    sdu_pkg::word_t step_sum;
    logic           step_sub;
    logic           step_take;
    sdu_pkg::word_t fix_sum;

    // Shift the 64-bit pair left by one
    assign shl_high = {state_cur.high_word[sdu_pkg::SIGN_BIT-1:0],
                       state_cur.low_word[sdu_pkg::SIGN_BIT]};
    assign shl_low  = {state_cur.low_word[sdu_pkg::SIGN_BIT-1:0], 1'b0};

    // Subtract when signs agree, add otherwise
    assign step_sub = (state_cur.dividend_sign == state_cur.divisor_sign);
    assign step_sum = step_sub ? (shl_high - operand) : (shl_high + operand);

    // Accept the step per sign case, comparing against the shifted high word
    always_comb
    begin
        case ({state_cur.dividend_sign, state_cur.divisor_sign})
            2'b00:   step_take = (step_sum <= shl_high);
            2'b01:   step_take = (step_sum <  shl_high);
            2'b10:   step_take = (step_sum >= shl_high);
            2'b11:   step_take = (step_sum >  shl_high);
            default: step_take = 1'b0;
        endcase
    end

    // Remainder fix-up sum
    assign fix_sum = state_cur.divisor_sign ? (state_cur.high_word - operand)
                                            : (state_cur.high_word + operand);

    // Select the next state by operation
    always_comb
    begin
        state_nxt = state_cur;
        trap      = 1'b0;
        case (kind)
            sdu_pkg::KIND_DIV0S:
            begin
                if (operand == '0)
                begin
                    trap = 1'b1;
                end
                else
                begin
                    state_nxt.dividend_sign = state_cur.low_word[sdu_pkg::SIGN_BIT];
                    state_nxt.high_word     = {sdu_pkg::WORD_W{
                                               state_cur.low_word[sdu_pkg::SIGN_BIT]}};
                    state_nxt.divisor_sign  = operand[sdu_pkg::SIGN_BIT];
                end
            end
            sdu_pkg::KIND_DIV0U:
            begin
                if (operand == '0)
                begin
                    trap = 1'b1;
                end
                else
                begin
                    state_nxt.high_word     = '0;
                    state_nxt.dividend_sign = 1'b0;
                    state_nxt.divisor_sign  = 1'b0;
                end
            end
            sdu_pkg::KIND_DIV1:
            begin
                state_nxt.high_word = step_take ? step_sum : shl_high;
                state_nxt.low_word  = {shl_low[sdu_pkg::SIGN_BIT:1], step_take};
            end
            sdu_pkg::KIND_DIV2S:
            begin
                if (state_cur.dividend_sign && (fix_sum == '0))
                begin
                    state_nxt.high_word = '0;
                    state_nxt.low_word  = state_cur.low_word + 32'd1;
                end
            end
            sdu_pkg::KIND_DIV3S:
            begin
                if (state_cur.dividend_sign != state_cur.divisor_sign)
                begin
                    state_nxt.low_word = '0 - state_cur.low_word;
                end
            end
            sdu_pkg::KIND_LOAD:
            begin
                state_nxt.low_word = operand;
            end
            default:
            begin
                state_nxt = state_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/step_division_unit_core.sv @@
// Step-division unit top level: request register, step logic, response register.
//
// Usage: each request on req carries one operation (kind) and a 32-bit operand:
// set-up signed/unsigned, one division step, remainder fix-up, quotient sign
// fix-up, or a dividend load. Each request produces exactly one response on rsp
// with the quotient (low) word, remainder (high) word, both sign flags and a
// zero-divide trap raised by a set-up with a zero divisor.
// Order: a request accepted on req is held in the request register, then executed
// against the divider state into the response register when rsp can take it.
// Throughput: one request per cycle while rsp is not held; the path that sets
// it is the single 32-bit add/subtract plus compare of the division step.
// Stall: while rsp is held, the response register holds and the request
// register takes one more request; req.ready then drops until rsp drains.
// Reset: rst_n clears the state pair, both sign flags and all valid bits.
`timescale 1ns / 1ps
`default_nettype none

module step_division_unit_core (
    input  wire logic clk,
    input  wire logic rst_n,
    sdu_req_if.sink   req,
    sdu_rsp_if.source rsp
);

    logic                req_valid_reg;
    logic [2:0]          kind_reg;
    sdu_pkg::word_t      operand_reg;
    logic                rsp_valid_reg;
    sdu_pkg::word_t      quotient_reg;
    sdu_pkg::word_t      remainder_reg;
    logic                dneg_reg;
    logic                vneg_reg;
    logic                trap_reg;
    sdu_pkg::sdu_state_t state_reg;
    sdu_pkg::sdu_state_t state_next;
    logic                trap_next;
    logic                advance;

    // Execute the held request when the response slot is free or draining
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg    <= req.kind;
            operand_reg <= req.operand;
        end
    end

    // Compute the step
    sdu_step u_step (
        .kind      (kind_reg),
        .operand   (operand_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .trap      (trap_next)
    );

    // Advance the divider state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the response payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quotient_reg  <= state_next.low_word;
            remainder_reg <= state_next.high_word;
            dneg_reg      <= state_next.dividend_sign;
            vneg_reg      <= state_next.divisor_sign;
            trap_reg      <= trap_next;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.quotient_word     = quotient_reg;
    assign rsp.remainder_word    = remainder_reg;
    assign rsp.dividend_negative = dneg_reg;
    assign rsp.divisor_negative  = vneg_reg;
    assign rsp.zero_divide_trap  = trap_reg;

    // A pending response always mirrors the current divider state
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (quotient_reg == state_reg.low_word)
                       && (remainder_reg == state_reg.high_word)
                       && (dneg_reg == state_reg.dividend_sign)
                       && (vneg_reg == state_reg.divisor_sign))
        else $error("response payload out of step with divider state");

    // A trapped set-up leaves the state untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && trap_next) |=> (state_reg == $past(state_reg)))
        else $error("zero-divide trap changed divider state");

    // A held request stays put until it executes
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !advance) |=> (req_valid_reg && $stable(kind_reg)
                                        && $stable(operand_reg)))
        else $error("stalled request lost or changed");

    // State changes only when a request executes
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (state_reg == $past(state_reg)))
        else $error("divider state changed without a request");

endmodule

`default_nettype wire

@@ verif/sdu_step_checker.sv @@
// Checker for the step-division unit: predicts each response and compares it field by field.
`timescale 1ns / 1ps

module sdu_step_checker (
    input  logic clk,
    input  logic rst_n,
    sdu_req_if   req,
    sdu_rsp_if   rsp,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        sdu_pkg::word_t quotient;
        sdu_pkg::word_t remainder;
        logic           dvd_neg;
        logic           dvs_neg;
        logic           trap;
    } step_result_t;

    // Predicted divider state
    sdu_pkg::word_t hi_q;
    sdu_pkg::word_t lo_q;
    logic           dvd_neg_q;
    logic           dvs_neg_q;

    step_result_t expected_steps[$];
    int error_count;
    int pending_count;

    assign errors  = error_count;
    assign pending = pending_count;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Advance the predicted state by one request and return the response it yields
    task automatic apply_division_op(input logic [2:0] kind, input sdu_pkg::word_t d,
                                     output step_result_t res);
        sdu_pkg::word_t sum;
        sdu_pkg::word_t fix;
        logic           take;
        logic           trap;
        trap = 1'b0;
        case (kind)
            sdu_pkg::KIND_DIV0S:
            begin
                if (d == '0)
                    trap = 1'b1;
                else
                begin
                    dvd_neg_q = lo_q[sdu_pkg::SIGN_BIT];
                    hi_q      = {sdu_pkg::WORD_W{lo_q[sdu_pkg::SIGN_BIT]}};
                    dvs_neg_q = d[sdu_pkg::SIGN_BIT];
                end
            end
            sdu_pkg::KIND_DIV0U:
            begin
                if (d == '0)
                    trap = 1'b1;
                else
                begin
                    hi_q      = '0;
                    dvd_neg_q = 1'b0;
                    dvs_neg_q = 1'b0;
                end
            end
            sdu_pkg::KIND_DIV1:
            begin
                // Shift the pair left, then try the add or subtract against the shifted high word
                hi_q = {hi_q[sdu_pkg::WORD_W-2:0], lo_q[sdu_pkg::SIGN_BIT]};
                lo_q = lo_q << 1;
                case ({dvd_neg_q, dvs_neg_q})
                    2'b00:
                    begin
                        sum  = hi_q - d;
                        take = (sum <= hi_q);
                    end
                    2'b01:
                    begin
                        sum  = hi_q + d;
                        take = (sum < hi_q);
                    end
                    2'b10:
                    begin
                        sum  = hi_q + d;
                        take = (sum >= hi_q);
                    end
                    default:
                    begin
                        sum  = hi_q - d;
                        take = (sum > hi_q);
                    end
                endcase
                if (take)
                begin
                    hi_q    = sum;
                    lo_q[0] = 1'b1;
                end
            end
            sdu_pkg::KIND_DIV2S:
            begin
                // Fix up the remainder only for a negative dividend
                if (dvd_neg_q)
                begin
                    fix = dvs_neg_q ? (hi_q - d) : (hi_q + d);
                    if (fix == '0)
                    begin
                        hi_q = '0;
                        lo_q = lo_q + sdu_pkg::word_t'(1);
                    end
                end
            end
            sdu_pkg::KIND_DIV3S:
            begin
                if (dvd_neg_q != dvs_neg_q)
                    lo_q = sdu_pkg::word_t'(0) - lo_q;
            end
            sdu_pkg::KIND_LOAD:
                lo_q = d;
            default:
                ;
        endcase
        res.quotient  = lo_q;
        res.remainder = hi_q;
        res.dvd_neg   = dvd_neg_q;
        res.dvs_neg   = dvs_neg_q;
        res.trap      = trap;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t want;
        step_result_t got;
        if (!rst_n)
        begin
            hi_q      = '0;
            lo_q      = '0;
            dvd_neg_q = 1'b0;
            dvs_neg_q = 1'b0;
            expected_steps.delete();
        end
        else
        begin
            // Check a response first: it can never belong to a request of this same edge
            if (rsp.valid && rsp.ready)
            begin
                got.quotient  = rsp.quotient_word;
                got.remainder = rsp.remainder_word;
                got.dvd_neg   = rsp.dividend_negative;
                got.dvs_neg   = rsp.divisor_negative;
                got.trap      = rsp.zero_divide_trap;
                if (expected_steps.size() == 0)
                    report_mismatch($sformatf("response with no request pending: %h", got));
                else
                begin
                    want = expected_steps.pop_front();
                    if (got.quotient !== want.quotient)
                        report_mismatch($sformatf("quotient_word got %h want %h",
                                                  got.quotient, want.quotient));
                    if (got.remainder !== want.remainder)
                        report_mismatch($sformatf("remainder_word got %h want %h",
                                                  got.remainder, want.remainder));
                    if (got.dvd_neg !== want.dvd_neg)
                        report_mismatch($sformatf("dividend_negative got %b want %b",
                                                  got.dvd_neg, want.dvd_neg));
                    if (got.dvs_neg !== want.dvs_neg)
                        report_mismatch($sformatf("divisor_negative got %b want %b",
                                                  got.dvs_neg, want.dvs_neg));
                    if (got.trap !== want.trap)
                        report_mismatch($sformatf("zero_divide_trap got %b want %b",
                                                  got.trap, want.trap));
                end
            end
            // Predict the response of a newly accepted request
            if (req.valid && req.ready)
            begin
                apply_division_op(req.kind, req.operand, want);
                expected_steps.push_back(want);
            end
        end
        pending_count = expected_steps.size();
    end

    initial
    begin
        error_count   = 0;
        pending_count = 0;
    end

endmodule

@@ verif/tb_step_division_unit_core.sv @@
// Testbench top for the step-division unit: clock, reset, request stimulus, response stalls, verdict.
`timescale 1ns / 1ps

module tb_step_division_unit_core;

    // Kinds the block treats as no operation
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam int RANDOM_ITEMS = 1850;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   items_sent;
    int   idle_cycles;
    int   stall_left;
    int   errors;
    int   pending;

    sdu_req_if req_ch ();
    sdu_rsp_if rsp_ch ();

    step_division_unit_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sdu_step_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Favor the corners of the 32-bit range
    function automatic sdu_pkg::word_t pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return sdu_pkg::word_t'($urandom_range(1, 15));
            5: return sdu_pkg::word_t'(0) - sdu_pkg::word_t'($urandom_range(1, 15));
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_op(input logic [2:0] kind, input sdu_pkg::word_t operand);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= kind;
        req_ch.operand <= operand;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind <= sdu_pkg::KIND_LOAD)
            items_sent++;
    endtask

    // One full or cut-short division with random operands
    task automatic run_division();
        sdu_pkg::word_t dividend;
        sdu_pkg::word_t divisor;
        int             steps;
        bit             signed_mode;
        dividend    = pick_operand();
        divisor     = pick_operand();
        signed_mode = 1'($urandom_range(0, 1));
        if (divisor == '0 && $urandom_range(0, 3) != 0)
            divisor = $urandom | 32'd1;
        steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 32;
        send_op(sdu_pkg::KIND_LOAD, dividend);
        send_op(signed_mode ? sdu_pkg::KIND_DIV0S : sdu_pkg::KIND_DIV0U, divisor);
        repeat (steps) send_op(sdu_pkg::KIND_DIV1, divisor);
        if (signed_mode)
        begin
            send_op(sdu_pkg::KIND_DIV2S, divisor);
            send_op(sdu_pkg::KIND_DIV3S, divisor);
        end
    endtask

    // Response side: stall for a random number of cycles, then pick again
    initial
    begin
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            stall_left = (stall_left > 0) ? stall_left - 1 : pick_idle();
            rsp_ch.ready <= (stall_left == 0);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        no_idle    = 1'b0;
        items_sent = 0;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= sdu_pkg::KIND_LOAD;
        req_ch.operand <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: traps, sign cases, fix-up with wrap, spare kinds
        send_op(sdu_pkg::KIND_LOAD, 32'hFFFF_FFFF);
        send_op(sdu_pkg::KIND_DIV0S, 32'h0000_0000);
        send_op(sdu_pkg::KIND_DIV0U, 32'h0000_0000);
        send_op(sdu_pkg::KIND_DIV0S, 32'h0000_0001);
        send_op(sdu_pkg::KIND_DIV2S, 32'h0000_0001);
        send_op(sdu_pkg::KIND_DIV3S, 32'h0000_0000);
        send_op(sdu_pkg::KIND_DIV1, 32'h0000_0001);
        send_op(sdu_pkg::KIND_LOAD, 32'h8000_0000);
        send_op(sdu_pkg::KIND_DIV0S, 32'hFFFF_FFFF);
        send_op(sdu_pkg::KIND_DIV1, 32'hFFFF_FFFF);
        send_op(sdu_pkg::KIND_DIV2S, 32'hFFFF_FFFF);
        send_op(sdu_pkg::KIND_DIV3S, 32'h0000_0000);
        send_op(sdu_pkg::KIND_LOAD, 32'h7FFF_FFFF);
        send_op(sdu_pkg::KIND_DIV0S, 32'h8000_0000);
        send_op(sdu_pkg::KIND_DIV1, 32'h8000_0000);
        send_op(sdu_pkg::KIND_DIV1, 32'h0000_0000);
        send_op(sdu_pkg::KIND_DIV0U, 32'hFFFF_FFFF);
        send_op(sdu_pkg::KIND_DIV1, 32'hFFFF_FFFF);
        send_op(sdu_pkg::KIND_DIV1, 32'h0000_0001);
        send_op(KIND_SPARE6, $urandom);
        send_op(KIND_SPARE7, 32'hFFFF_FFFF);
        send_op(sdu_pkg::KIND_LOAD, 32'h0000_0000);
        send_op(sdu_pkg::KIND_DIV0S, 32'h0000_0005);
        send_op(sdu_pkg::KIND_DIV1, 32'h0000_0000);
        send_op(sdu_pkg::KIND_DIV3S, 32'hFFFF_FFFF);

        // Random: mostly whole divisions, the rest loose requests of any kind
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) != 0)
                run_division();
            else
                repeat ($urandom_range(1, 8)) send_op(3'($urandom_range(0, 7)), pick_operand());
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then settle
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
